// ===== hw/rtl/crm_pkg.sv =====
// ---------------------------------------------------------------------------
// crm_pkg: shared types and constants of the cascaded interval remap block
// Request codes, default sizes and the control word that travels with every
// transaction along the cell chain.
// ---------------------------------------------------------------------------
package crm_pkg;

   // default sizes
   localparam int STAGES_DEF            = 8;
   localparam int ENTRIES_PER_STAGE_DEF = 32;
   localparam int VALUE_BITS_DEF        = 32;

   // fixed field widths
   localparam int REQ_TYPE_BITS = 2;
   localparam int STAGE_BITS    = 3;
   localparam int SLOT_BITS     = 5;
   localparam int WORD_BITS     = 32;
   localparam int CSR_BITS      = 4;

   localparam logic [CSR_BITS-1:0] STAGES_IN_USE_RST = 4'd7;

   // request codes
   localparam logic [REQ_TYPE_BITS-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_XLATE = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR = 2'd2;

   // control word of one transaction in flight
   typedef struct packed {
      logic                     live;         // slot holds a transaction
      logic [REQ_TYPE_BITS-1:0] kind;
      logic [STAGE_BITS-1:0]    stage;        // load target
      logic [SLOT_BITS-1:0]     slot;         // load target
      logic                     entry_valid;  // load valid bit
      logic                     matched;      // translate hit in current stage
      logic                     ovf;          // translate saturated somewhere
   } token_ctl_type;

endpackage

// ===== hw/rtl/crm_cell.sv =====
// ---------------------------------------------------------------------------
// crm_cell: one table entry of one remap stage
// Holds its entry, writes it when a matching load passes, and remaps a
// passing translate value if no earlier entry of the same stage hit.
// ---------------------------------------------------------------------------
module crm_cell #(
   parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF,
   parameter int STAGE_IDX  = 0,
   parameter int SLOT_IDX   = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [crm_pkg::CSR_BITS-1:0]          stages_in_use,
   input  crm_pkg::token_ctl_type                ctl_i,
   input  logic [VALUE_BITS-1:0]                 d0_i,
   input  logic [VALUE_BITS-1:0]                 d1_i,
   input  logic [VALUE_BITS-1:0]                 d2_i,
   output crm_pkg::token_ctl_type                ctl_o,
   output logic [VALUE_BITS-1:0]                 d0_o,
   output logic [VALUE_BITS-1:0]                 d1_o,
   output logic [VALUE_BITS-1:0]                 d2_o
);

   // entry store
   logic                  ent_valid_ff;
   logic [VALUE_BITS-1:0] ent_src_ff;
   logic [VALUE_BITS-1:0] ent_dst_ff;
   logic [VALUE_BITS-1:0] ent_len_ff;

   // pipeline stage
   crm_pkg::token_ctl_type ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0]  d0_ff, d0_in;
   logic [VALUE_BITS-1:0]  d1_ff;
   logic [VALUE_BITS-1:0]  d2_ff;

   logic                  stage_active;
   logic                  matched_prev;
   logic                  load_here;
   logic                  hit;
   logic [VALUE_BITS:0]   diff;
   logic [VALUE_BITS:0]   sum;
   logic [VALUE_BITS-1:0] remapped;

   always_comb begin
      stage_active = (STAGE_IDX < int'(stages_in_use));
      // first slot of a stage starts a fresh search
      matched_prev = (SLOT_IDX == 0) ? 1'b0 : ctl_i.matched;
      diff     = {1'b0, d0_i} - {1'b0, ent_src_ff};
      sum      = {1'b0, ent_dst_ff} + {1'b0, diff[VALUE_BITS-1:0]};
      remapped = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
      hit = ctl_i.live && (ctl_i.kind == crm_pkg::REQ_XLATE) && stage_active
            && !matched_prev && ent_valid_ff && !diff[VALUE_BITS]
            && (diff[VALUE_BITS-1:0] < ent_len_ff);
      load_here = ctl_i.live && (ctl_i.kind == crm_pkg::REQ_LOAD)
                  && (int'(ctl_i.stage) == STAGE_IDX)
                  && (int'(ctl_i.slot) == SLOT_IDX);

      ctl_in         = ctl_i;
      ctl_in.matched = matched_prev | hit;
      ctl_in.ovf     = ctl_i.ovf | (hit & sum[VALUE_BITS]);
      d0_in          = hit ? remapped : d0_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         ent_valid_ff <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         if (load_here) begin
            ent_valid_ff <= ctl_i.entry_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_ff <= d0_in;
         d1_ff <= d1_i;
         d2_ff <= d2_i;
         if (load_here) begin
            ent_src_ff <= d0_i;
            ent_dst_ff <= d1_i;
            ent_len_ff <= d2_i;
         end
      end
   end

   assign ctl_o = ctl_ff;
   assign d0_o  = d0_ff;
   assign d1_o  = d1_ff;
   assign d2_o  = d2_ff;

endmodule

// ===== hw/rtl/crm_tail.sv =====
// ---------------------------------------------------------------------------
// crm_tail: running minimum and response register
// Consumes transactions leaving the chain; clears the minimum, or folds a
// translated value into it and presents the response.
// ---------------------------------------------------------------------------
module crm_tail #(
   parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crm_pkg::token_ctl_type            ctl_i,
   input  logic [VALUE_BITS-1:0]             d0_i,
   output logic                              advance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [crm_pkg::WORD_BITS-1:0]     rsp_mapped_value,
   output logic [crm_pkg::WORD_BITS-1:0]     rsp_running_minimum,
   output logic                              rsp_overflow_flag
);

   logic                            min_seen_ff;
   logic [crm_pkg::WORD_BITS-1:0]   min_value_ff, min_value_in;
   logic                            rsp_valid_ff;
   logic [crm_pkg::WORD_BITS-1:0]   mapped_ff;
   logic [crm_pkg::WORD_BITS-1:0]   minimum_ff;
   logic                            ovf_ff;

   logic [63:0]                     value_wide;
   logic [crm_pkg::WORD_BITS-1:0]   value_w;
   logic                            is_xlate;
   logic                            is_clear;

   assign advance = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      value_wide   = 64'(d0_i);
      value_w      = value_wide[crm_pkg::WORD_BITS-1:0];
      is_xlate     = ctl_i.live && (ctl_i.kind == crm_pkg::REQ_XLATE);
      is_clear     = ctl_i.live && (ctl_i.kind == crm_pkg::REQ_CLEAR);
      min_value_in = (!min_seen_ff || (value_w < min_value_ff)) ? value_w : min_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_seen_ff  <= 1'b0;
         min_value_ff <= '1;
      end else if (advance) begin
         rsp_valid_ff <= is_xlate;
         if (is_clear) begin
            min_seen_ff  <= 1'b0;
            min_value_ff <= '1;
         end else if (is_xlate) begin
            min_seen_ff  <= 1'b1;
            min_value_ff <= min_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_xlate) begin
         mapped_ff  <= value_w;
         minimum_ff <= min_value_in;
         ovf_ff     <= ctl_i.ovf;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mapped_value    = mapped_ff;
   assign rsp_running_minimum = minimum_ff;
   assign rsp_overflow_flag   = ovf_ff;

endmodule

// ===== hw/rtl/cascaded_interval_remap_top.sv =====
// ---------------------------------------------------------------------------
// cascaded_interval_remap_top: cascade of interval remap stages
// A value is remapped by up to STAGES tables in turn; each table entry is a
// cell of one long chain that every transaction walks through.
// ---------------------------------------------------------------------------
//
//   channel | direction | ports                     | moves
//   --------+-----------+---------------------------+----------------------------
//   req     | in        | req_valid / req_stall     | load, translate, clear
//   rsp     | out       | rsp_valid / rsp_stall     | mapped value, minimum, flag
//   csr     | in        | csr_write_en              | stages_in_use, no read-back
//
// One transaction enters the chain per cycle unless a held response freezes it.
// The chain has STAGES * ENTRIES_PER_STAGE cells, one per table entry,
// each a register; a translate response passes through every cell and
// then the response register of the tail.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// A held response under rsp_stall freezes the whole chain and raises
// req_stall in the same cycle.
// ---------------------------------------------------------------------------
module cascaded_interval_remap_top #(
   parameter int STAGES            = crm_pkg::STAGES_DEF,
   parameter int ENTRIES_PER_STAGE = crm_pkg::ENTRIES_PER_STAGE_DEF,
   parameter int VALUE_BITS        = crm_pkg::VALUE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [crm_pkg::CSR_BITS-1:0]           csr_stages_in_use,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [crm_pkg::REQ_TYPE_BITS-1:0]      req_type,
   input  logic [crm_pkg::STAGE_BITS-1:0]         req_stage_number,
   input  logic [crm_pkg::SLOT_BITS-1:0]          req_slot_number,
   input  logic                                   req_entry_valid,
   input  logic [crm_pkg::WORD_BITS-1:0]          req_range_source_start,
   input  logic [crm_pkg::WORD_BITS-1:0]          req_range_dest_start,
   input  logic [crm_pkg::WORD_BITS-1:0]          req_range_length,
   input  logic [crm_pkg::WORD_BITS-1:0]          req_seed_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [crm_pkg::WORD_BITS-1:0]          rsp_mapped_value,
   output logic [crm_pkg::WORD_BITS-1:0]          rsp_running_minimum,
   output logic                                   rsp_overflow_flag
);

   localparam int CELLS = STAGES * ENTRIES_PER_STAGE;

   logic [crm_pkg::CSR_BITS-1:0] stages_in_use_ff;
   logic                         advance;

   // chain links: link i feeds cell i, link CELLS feeds the tail
   crm_pkg::token_ctl_type ctl_chain [0:CELLS];
   logic [VALUE_BITS-1:0]  d0_chain  [0:CELLS];
   logic [VALUE_BITS-1:0]  d1_chain  [0:CELLS-1];
   logic [VALUE_BITS-1:0]  d2_chain  [0:CELLS-1];

   // head of the chain
   crm_pkg::token_ctl_type inject_ctl;
   logic [VALUE_BITS-1:0]  inject_d0;
   logic [VALUE_BITS-1:0]  inject_d1;
   logic [VALUE_BITS-1:0]  inject_d2;

   logic [63:0] src_wide, dst_wide, len_wide, seed_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         stages_in_use_ff <= crm_pkg::STAGES_IN_USE_RST;
      end else if (csr_write_en) begin
         stages_in_use_ff <= csr_stages_in_use;
      end
   end

   assign req_stall = !advance;

   // Injection. Words are cut or zero-extended to the value width; a
   // translate carries its value in the first data word. Unknown request
   // codes are accepted and dropped here.
   always_comb begin
      src_wide  = {32'b0, req_range_source_start};
      dst_wide  = {32'b0, req_range_dest_start};
      len_wide  = {32'b0, req_range_length};
      seed_wide = {32'b0, req_seed_value};

      inject_ctl.live        = req_valid && ((req_type == crm_pkg::REQ_LOAD)
                               || (req_type == crm_pkg::REQ_XLATE)
                               || (req_type == crm_pkg::REQ_CLEAR));
      inject_ctl.kind        = req_type;
      inject_ctl.stage       = req_stage_number;
      inject_ctl.slot        = req_slot_number;
      inject_ctl.entry_valid = req_entry_valid;
      inject_ctl.matched     = 1'b0;
      inject_ctl.ovf         = 1'b0;

      inject_d0 = (req_type == crm_pkg::REQ_XLATE) ? seed_wide[VALUE_BITS-1:0]
                                                   : src_wide[VALUE_BITS-1:0];
      inject_d1 = dst_wide[VALUE_BITS-1:0];
      inject_d2 = len_wide[VALUE_BITS-1:0];
   end

   assign ctl_chain[0] = inject_ctl;
   assign d0_chain[0]  = inject_d0;
   assign d1_chain[0]  = inject_d1;
   assign d2_chain[0]  = inject_d2;

   // cell chain, stage-major order
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      for (genvar k = 0; k < ENTRIES_PER_STAGE; k++) begin : g_slot
         localparam int IDX = s * ENTRIES_PER_STAGE + k;
         if (IDX < CELLS - 1) begin : g_mid
            crm_cell #(
               .VALUE_BITS (VALUE_BITS),
               .STAGE_IDX  (s),
               .SLOT_IDX   (k)
            ) u_cell (
               .clock         (clock),
               .reset         (reset),
               .advance       (advance),
               .stages_in_use (stages_in_use_ff),
               .ctl_i         (ctl_chain[IDX]),
               .d0_i          (d0_chain[IDX]),
               .d1_i          (d1_chain[IDX]),
               .d2_i          (d2_chain[IDX]),
               .ctl_o         (ctl_chain[IDX+1]),
               .d0_o          (d0_chain[IDX+1]),
               .d1_o          (d1_chain[IDX+1]),
               .d2_o          (d2_chain[IDX+1])
            );
         end else begin : g_last
            // load data goes no further than the last cell
            crm_cell #(
               .VALUE_BITS (VALUE_BITS),
               .STAGE_IDX  (s),
               .SLOT_IDX   (k)
            ) u_cell (
               .clock         (clock),
               .reset         (reset),
               .advance       (advance),
               .stages_in_use (stages_in_use_ff),
               .ctl_i         (ctl_chain[IDX]),
               .d0_i          (d0_chain[IDX]),
               .d1_i          (d1_chain[IDX]),
               .d2_i          (d2_chain[IDX]),
               .ctl_o         (ctl_chain[IDX+1]),
               .d0_o          (d0_chain[IDX+1]),
               .d1_o          (),
               .d2_o          ()
            );
         end
      end
   end

   crm_tail #(
      .VALUE_BITS (VALUE_BITS)
   ) u_tail (
      .clock               (clock),
      .reset               (reset),
      .ctl_i               (ctl_chain[CELLS]),
      .d0_i                (d0_chain[CELLS]),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mapped_value    (rsp_mapped_value),
      .rsp_running_minimum (rsp_running_minimum),
      .rsp_overflow_flag   (rsp_overflow_flag)
   );

endmodule

// ===== tb/sv/cascaded_interval_remap_checker.sv =====
// ---------------------------------------------------------------------------
// cascaded_interval_remap_checker: transaction predictor and response checker
// Watches the csr, req and rsp channels of the remap block. It keeps its own
// copy of the entry tables, the stage count and the running minimum, works
// out the response of every accepted translate, and compares each accepted
// response field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module cascaded_interval_remap_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [crm_pkg::CSR_BITS-1:0]      csr_stages_in_use,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [crm_pkg::REQ_TYPE_BITS-1:0] req_type,
   input  logic [crm_pkg::STAGE_BITS-1:0]    req_stage_number,
   input  logic [crm_pkg::SLOT_BITS-1:0]     req_slot_number,
   input  logic                              req_entry_valid,
   input  logic [crm_pkg::WORD_BITS-1:0]     req_range_source_start,
   input  logic [crm_pkg::WORD_BITS-1:0]     req_range_dest_start,
   input  logic [crm_pkg::WORD_BITS-1:0]     req_range_length,
   input  logic [crm_pkg::WORD_BITS-1:0]     req_seed_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [crm_pkg::WORD_BITS-1:0]     rsp_mapped_value,
   input  logic [crm_pkg::WORD_BITS-1:0]     rsp_running_minimum,
   input  logic                              rsp_overflow_flag,
   output int                                fail_count,
   output int                                pending_results
);

   localparam int TABLE_DEPTH = crm_pkg::STAGES_DEF * crm_pkg::ENTRIES_PER_STAGE_DEF;

   typedef struct packed {
      logic [crm_pkg::WORD_BITS-1:0] mapped;
      logic [crm_pkg::WORD_BITS-1:0] minimum;
      logic                          ovf;
   } remap_result_type;

   // shadow tables, one flat array per field
   logic [crm_pkg::WORD_BITS-1:0] src_start [TABLE_DEPTH];
   logic [crm_pkg::WORD_BITS-1:0] dst_start [TABLE_DEPTH];
   logic [crm_pkg::WORD_BITS-1:0] span      [TABLE_DEPTH];
   logic                          live      [TABLE_DEPTH];
   logic [crm_pkg::WORD_BITS-1:0] min_mapped;
   logic                          min_valid;
   logic [crm_pkg::CSR_BITS-1:0]  stage_count;
   remap_result_type              expected_q [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what,
                                  input logic [crm_pkg::WORD_BITS-1:0] got,
                                  input logic [crm_pkg::WORD_BITS-1:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // walk the seed through the stages in use; first live hit in a stage wins
   function automatic remap_result_type remap_seed(input logic [crm_pkg::WORD_BITS-1:0] seed);
      remap_result_type              res;
      logic [crm_pkg::WORD_BITS-1:0] v;
      logic [crm_pkg::WORD_BITS:0]   sum;
      logic                          hit;
      int                            n;
      int                            s;
      int                            k;
      int                            idx;
      n = (stage_count > crm_pkg::STAGES_DEF) ? crm_pkg::STAGES_DEF : int'(stage_count);
      v = seed;
      res.ovf = 1'b0;
      for (s = 0; s < n; s++) begin
         hit = 1'b0;
         for (k = 0; k < crm_pkg::ENTRIES_PER_STAGE_DEF && !hit; k++) begin
            idx = s * crm_pkg::ENTRIES_PER_STAGE_DEF + k;
            if (live[idx] && v >= src_start[idx] && (v - src_start[idx]) < span[idx]) begin
               hit = 1'b1;
               sum = {1'b0, dst_start[idx]} + {1'b0, v - src_start[idx]};
               if (sum[crm_pkg::WORD_BITS]) begin
                  res.ovf = 1'b1;
                  v       = '1;
               end else begin
                  v = sum[crm_pkg::WORD_BITS-1:0];
               end
            end
         end
      end
      res.mapped  = v;
      res.minimum = '0;
      return res;
   endfunction

   always @(posedge clock) begin : track
      remap_result_type want;
      int               idx;
      if (reset) begin
         foreach (live[i]) live[i] = 1'b0;
         min_mapped  = '1;
         min_valid   = 1'b0;
         stage_count = crm_pkg::STAGES_IN_USE_RST;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with none expected", rsp_mapped_value, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_mapped_value !== want.mapped)
                  report_mismatch("mapped_value", rsp_mapped_value, want.mapped);
               if (rsp_running_minimum !== want.minimum)
                  report_mismatch("running_minimum", rsp_running_minimum, want.minimum);
               if (rsp_overflow_flag !== want.ovf)
                  report_mismatch("overflow_flag",
                                  {{(crm_pkg::WORD_BITS-1){1'b0}}, rsp_overflow_flag},
                                  {{(crm_pkg::WORD_BITS-1){1'b0}}, want.ovf});
            end
         end
         if (csr_write_en)
            stage_count = csr_stages_in_use;
         if (req_valid && !req_stall) begin
            case (req_type)
               crm_pkg::REQ_LOAD: begin
                  idx = int'(req_stage_number) * crm_pkg::ENTRIES_PER_STAGE_DEF
                        + int'(req_slot_number);
                  if (req_stage_number < crm_pkg::STAGES_DEF
                      && req_slot_number < crm_pkg::ENTRIES_PER_STAGE_DEF) begin
                     live[idx]      = req_entry_valid;
                     src_start[idx] = req_range_source_start;
                     dst_start[idx] = req_range_dest_start;
                     span[idx]      = req_range_length;
                  end
               end
               crm_pkg::REQ_CLEAR: begin
                  min_mapped = '1;
                  min_valid  = 1'b0;
               end
               crm_pkg::REQ_XLATE: begin
                  want = remap_seed(req_seed_value);
                  if (!min_valid || want.mapped < min_mapped)
                     min_mapped = want.mapped;
                  min_valid    = 1'b1;
                  want.minimum = min_mapped;
                  expected_q.insert(expected_q.size(), want);
               end
               default: ;  // unused code, dropped by the block
            endcase
         end
      end
      pending_results <= expected_q.size();
   end

endmodule

// ===== tb/sv/cascaded_interval_remap_top_tb.sv =====
// ---------------------------------------------------------------------------
// cascaded_interval_remap_top_tb: testbench top of the interval remap cascade
// Drives a directed opening and then phases of random loads, translates and
// clears, each phase under its own stage count and idle/stall pattern. The
// checker beside the block predicts and compares every response; this
// module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module cascaded_interval_remap_top_tb;

   // request code the block must drop without a response
   localparam logic [crm_pkg::REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;

   // cell count of the chain at the default sizes; a translate passes each one
   localparam int CHAIN_LATENCY = crm_pkg::STAGES_DEF * crm_pkg::ENTRIES_PER_STAGE_DEF;
   // run watchdog limit
   localparam int CYCLE_LIMIT   = 600_000;

   typedef struct {
      logic [crm_pkg::REQ_TYPE_BITS-1:0] kind;
      logic [crm_pkg::STAGE_BITS-1:0]    stage;
      logic [crm_pkg::SLOT_BITS-1:0]     slot;
      logic                              entry_valid;
      logic [crm_pkg::WORD_BITS-1:0]     src_start;
      logic [crm_pkg::WORD_BITS-1:0]     dst_start;
      logic [crm_pkg::WORD_BITS-1:0]     span;
      logic [crm_pkg::WORD_BITS-1:0]     seed;
   } remap_req_type;

   // every block input has a known value from time zero
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_en = 1'b0;
   logic [crm_pkg::CSR_BITS-1:0]      csr_stages_in_use = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [crm_pkg::REQ_TYPE_BITS-1:0] req_type = '0;
   logic [crm_pkg::STAGE_BITS-1:0]    req_stage_number = '0;
   logic [crm_pkg::SLOT_BITS-1:0]     req_slot_number = '0;
   logic                              req_entry_valid = 1'b0;
   logic [crm_pkg::WORD_BITS-1:0]     req_range_source_start = '0;
   logic [crm_pkg::WORD_BITS-1:0]     req_range_dest_start = '0;
   logic [crm_pkg::WORD_BITS-1:0]     req_range_length = '0;
   logic [crm_pkg::WORD_BITS-1:0]     req_seed_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [crm_pkg::WORD_BITS-1:0]     rsp_mapped_value;
   logic [crm_pkg::WORD_BITS-1:0]     rsp_running_minimum;
   logic                              rsp_overflow_flag;

   int fail_count;
   int pending_results;
   int cycle_count = 0;
   int idle_pct    = 0;   // chance in 100 that the sender idles a cycle
   int stall_pct   = 0;   // chance in 100 that the receiver stalls a cycle

   cascaded_interval_remap_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_en           (csr_write_en),
      .csr_stages_in_use      (csr_stages_in_use),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_type               (req_type),
      .req_stage_number       (req_stage_number),
      .req_slot_number        (req_slot_number),
      .req_entry_valid        (req_entry_valid),
      .req_range_source_start (req_range_source_start),
      .req_range_dest_start   (req_range_dest_start),
      .req_range_length       (req_range_length),
      .req_seed_value         (req_seed_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_mapped_value       (rsp_mapped_value),
      .rsp_running_minimum    (rsp_running_minimum),
      .rsp_overflow_flag      (rsp_overflow_flag)
   );

   cascaded_interval_remap_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_en           (csr_write_en),
      .csr_stages_in_use      (csr_stages_in_use),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_type               (req_type),
      .req_stage_number       (req_stage_number),
      .req_slot_number        (req_slot_number),
      .req_entry_valid        (req_entry_valid),
      .req_range_source_start (req_range_source_start),
      .req_range_dest_start   (req_range_dest_start),
      .req_range_length       (req_range_length),
      .req_seed_value         (req_seed_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_mapped_value       (rsp_mapped_value),
      .rsp_running_minimum    (rsp_running_minimum),
      .rsp_overflow_flag      (rsp_overflow_flag),
      .fail_count             (fail_count),
      .pending_results        (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // watchdog: a hung chain or a lost response ends here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("cascaded_interval_remap_top_tb failed");
      $finish;
   end

   // receiver: one stall decision per cycle, pattern set by the phase
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // ---- value shaping ------------------------------------------------------
   // Most values sit in a small window so that seeds land inside loaded
   // intervals and hop from stage to stage; some sit just under the top of
   // the range to provoke saturation; the rest are full-width noise.
   function automatic logic [crm_pkg::WORD_BITS-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return $urandom_range(511);
      if (roll < 75)
         return 32'hFFFF_FE00 | $urandom_range(511);
      return $urandom;
   endfunction

   // interval lengths: some zero (never matches), mostly short, a few huge
   function automatic logic [crm_pkg::WORD_BITS-1:0] pick_span();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      if (roll < 60)
         return $urandom_range(128, 1);
      if (roll < 85)
         return $urandom_range(512, 1);
      return $urandom;
   endfunction

   // all fields random; callers overwrite what the transaction uses
   function automatic remap_req_type noise_request(
      input logic [crm_pkg::REQ_TYPE_BITS-1:0] kind);
      remap_req_type r;
      logic [31:0]   rnd;
      r.kind        = kind;
      rnd           = $urandom;
      r.stage       = rnd[crm_pkg::STAGE_BITS-1:0];
      rnd           = $urandom;
      r.slot        = rnd[crm_pkg::SLOT_BITS-1:0];
      rnd           = $urandom;
      r.entry_valid = rnd[0];
      r.src_start   = $urandom;
      r.dst_start   = $urandom;
      r.span        = $urandom;
      r.seed        = $urandom;
      return r;
   endfunction

   function automatic remap_req_type load_request(input int stage, input int slot,
                                                  input logic on,
                                                  input logic [crm_pkg::WORD_BITS-1:0] src,
                                                  input logic [crm_pkg::WORD_BITS-1:0] dst,
                                                  input logic [crm_pkg::WORD_BITS-1:0] len);
      remap_req_type r;
      logic [31:0]   stage_bits;
      logic [31:0]   slot_bits;
      stage_bits    = stage;
      slot_bits     = slot;
      r             = noise_request(crm_pkg::REQ_LOAD);
      r.stage       = stage_bits[crm_pkg::STAGE_BITS-1:0];
      r.slot        = slot_bits[crm_pkg::SLOT_BITS-1:0];
      r.entry_valid = on;
      r.src_start   = src;
      r.dst_start   = dst;
      r.span        = len;
      return r;
   endfunction

   function automatic remap_req_type xlate_request(input logic [crm_pkg::WORD_BITS-1:0] seed);
      remap_req_type r;
      r      = noise_request(crm_pkg::REQ_XLATE);
      r.seed = seed;
      return r;
   endfunction

   // random mix: loads build the tables, translates dominate, clears and
   // unused codes are sprinkled in
   function automatic remap_req_type random_request();
      remap_req_type r;
      int            roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         // low slots mostly, so that entries compete for priority
         r = load_request($urandom_range(7),
                          ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(7),
                          $urandom_range(99) < 85, pick_value(), pick_value(), pick_span());
      end else if (roll < 90) begin
         r = xlate_request(pick_value());
      end else if (roll < 95) begin
         r = noise_request(crm_pkg::REQ_CLEAR);
      end else begin
         r = noise_request(REQ_UNUSED);
      end
      return r;
   endfunction

   // ---- channel drivers ----------------------------------------------------
   // Idle cycles come first with valid low; the transaction then stays on
   // the bus until an edge with stall low. Valid is left high on return so
   // that back-to-back transactions never lower and raise it in one step.
   task automatic send_request(input remap_req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_type               <= r.kind;
      req_stage_number       <= r.stage;
      req_slot_number        <= r.slot;
      req_entry_valid        <= r.entry_valid;
      req_range_source_start <= r.src_start;
      req_range_dest_start   <= r.dst_start;
      req_range_length       <= r.span;
      req_seed_value         <= r.seed;
      do @(posedge clock); while (req_stall);
   endtask

   // sender holds off until every predicted response has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // loads and clears leave no response behind, so let the chain empty
   // fully before the stage count changes under it
   task automatic write_stage_count(input logic [crm_pkg::CSR_BITS-1:0] n);
      drain_results();
      repeat (CHAIN_LATENCY + 8) @(posedge clock);
      csr_write_en      <= 1'b1;
      csr_stages_in_use <= n;
      @(posedge clock);
      csr_write_en      <= 1'b0;
   endtask

   task automatic run_phase(input logic [crm_pkg::CSR_BITS-1:0] n, input int send_idle,
                            input int rsp_idle, input int count, input logic pause_midway);
      remap_req_type r;
      int            sent;
      logic          paused;
      write_stage_count(n);
      idle_pct  = send_idle;
      stall_pct = rsp_idle;
      sent      = 0;
      paused    = 1'b0;
      while (sent < count) begin
         r = random_request();
         send_request(r);
         // unused codes are dropped by the block and do not count
         if (r.kind != REQ_UNUSED)
            sent++;
         if (pause_midway && !paused && sent == count / 2) begin
            paused = 1'b1;
            drain_results();
         end
      end
   endtask

   // directed opening, run at the reset stage count (stages 0..6 active)
   task automatic directed_opening();
      send_request(xlate_request('0));                  // empty tables: pass through
      send_request(xlate_request('1));                  // minimum must stay at zero
      send_request(noise_request(crm_pkg::REQ_CLEAR));
      send_request(xlate_request(32'd5));               // minimum restarts
      send_request(load_request(0, 0, 1'b1, 32'd0, 32'd100, 32'd10));
      send_request(load_request(0, 1, 1'b1, 32'd0, 32'd500, 32'd20));
      send_request(xlate_request(32'd3));               // both cover it, slot 0 wins
      send_request(xlate_request(32'd15));              // only slot 1 covers it
      send_request(xlate_request(32'd20));              // one past the end: no hit
      send_request(load_request(0, 31, 1'b1, 32'd1000, 32'hFFFF_FFF0, 32'h100));
      send_request(xlate_request(32'd1000));            // maps to top range, no overflow
      send_request(xlate_request(32'd1020));            // saturates, flag raised
      // stage 1 catches the saturated value and carries it on to zero
      send_request(load_request(1, 0, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
      send_request(load_request(2, 0, 1'b1, 32'd0, 32'd7, 32'd0));          // zero length
      send_request(load_request(3, 5, 1'b0, 32'd0, 32'd9, 32'hFFFF_FFFF));  // disabled
      send_request(load_request(7, 31, 1'b1, 32'd0, 32'd1, 32'hFFFF_FFFF)); // stage 7
      send_request(noise_request(REQ_UNUSED));
      send_request(xlate_request(32'd1020));
      send_request(xlate_request('1));
      send_request(noise_request(crm_pkg::REQ_CLEAR));
      send_request(xlate_request(32'd12));
      send_request(xlate_request(32'h8000_0000));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0: reset stage count, no idling
      directed_opening();
      idle_pct  = 0;
      stall_pct = 0;
      begin : reset_count_phase
         int k;
         for (k = 0; k < 200; k++)
            send_request(random_request());
      end

      // stage counts from one to the full cascade, zero, and above the
      // cascade depth; the four idle patterns rotate underneath
      run_phase(4'd1,  81, 0,  180, 1'b0);
      run_phase(4'd8,  0,  81, 180, 1'b0);
      run_phase(4'd0,  19, 19, 150, 1'b0);
      run_phase(4'd15, 0,  0,  180, 1'b1);
      run_phase(4'd4,  81, 0,  180, 1'b0);
      run_phase(4'd8,  0,  81, 200, 1'b0);
      run_phase(4'd2,  19, 19, 170, 1'b0);

      // all responses in, then a quiet window for anything stray
      drain_results();
      repeat (CHAIN_LATENCY + 16) @(posedge clock);
      if (fail_count == 0)
         $display("cascaded_interval_remap_top_tb passed");
      else
         $display("cascaded_interval_remap_top_tb failed");
      $finish;
   end

endmodule
